[hw/rtl/rpa_pkg.sv]
package rpa_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int AXIS_W          = 16;
	localparam int ANGLE_W         = 16;
	localparam int CORDIC_N        = 16;
	localparam int XY_W            = 32;
	localparam int Z_W             = 24;
	localparam int TRIG_W          = 19;
	localparam int OMC_W           = 20;
	localparam int FULL_TURN       = 23040;
	localparam int HALF_TURN       = 11520;
	localparam int QUARTER_TURN    = 5760;
	localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sd652032874;

	// atan(2^-i) in 1/16384 degree
	function automatic logic signed [Z_W-1:0] atan_at(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:       r = 24'sd737280;
			1:       r = 24'sd435242;
			2:       r = 24'sd229970;
			3:       r = 24'sd116736;
			4:       r = 24'sd58595;
			5:       r = 24'sd29326;
			6:       r = 24'sd14667;
			7:       r = 24'sd7334;
			8:       r = 24'sd3667;
			9:       r = 24'sd1833;
			10:      r = 24'sd917;
			11:      r = 24'sd458;
			12:      r = 24'sd229;
			13:      r = 24'sd115;
			14:      r = 24'sd57;
			15:      r = 24'sd29;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/rpa_req_if.sv]
interface rpa_req_if import rpa_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
);
	logic                      valid;
	logic                      ready;
	logic signed [AXIS_W-1:0]  axis_x;
	logic signed [AXIS_W-1:0]  axis_y;
	logic signed [AXIS_W-1:0]  axis_z;
	logic signed [CW-1:0]      point_x;
	logic signed [CW-1:0]      point_y;
	logic signed [CW-1:0]      point_z;
	logic signed [ANGLE_W-1:0] angle;

	modport source (output valid, axis_x, axis_y, axis_z, point_x, point_y, point_z, angle,
		input ready);
	modport sink (input valid, axis_x, axis_y, axis_z, point_x, point_y, point_z, angle,
		output ready);
endinterface

[hw/rtl/rpa_rsp_if.sv]
interface rpa_rsp_if import rpa_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic signed [CW-1:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

[hw/rtl/rpa_cordic.sv]
module rpa_cordic import rpa_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [Z_W-1:0]  z_in,
	input  logic                   neg_in,
	output logic signed [XY_W-1:0] x_out,
	output logic signed [XY_W-1:0] y_out,
	output logic                   neg_out
);

	logic signed [XY_W-1:0] x_s   [CORDIC_N];
	logic signed [XY_W-1:0] y_s   [CORDIC_N];
	logic signed [Z_W-1:0]  z_s   [CORDIC_N];
	logic                   neg_s [CORDIC_N];

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_it
		logic signed [XY_W-1:0] xi, yi;
		logic signed [Z_W-1:0]  zi;
		logic                   ni;
		if (i == 0) begin : g_first
			assign xi = CORDIC_X0;
			assign yi = '0;
			assign zi = z_in;
			assign ni = neg_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ni = neg_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - atan_at(i);
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + atan_at(i);
				end
				neg_s[i] <= ni;
			end
		end
	end

	assign x_out   = x_s[CORDIC_N-1];
	assign y_out   = y_s[CORDIC_N-1];
	assign neg_out = neg_s[CORDIC_N-1];

endmodule

[hw/rtl/rpa_geom.sv]
module rpa_geom import rpa_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AXIS_W-1:0] a_in [3],
	input  logic signed [CW-1:0]     p_in [3],
	output logic signed [CW-1:0]     p_out [3],
	output logic signed [CW+4:0]     cr_out [3],
	output logic signed [CW+7:0]     ad_out [3]
);

	localparam int PW = AXIS_W + CW;   // one product
	localparam int SW = CW + 18;       // sum of up to three products
	localparam int DW = CW + 5;        // dot / cross after rounding
	localparam int AW = AXIS_W + DW;   // a_k * dot
	localparam logic signed [SW:0] HALF_S = (SW+1)'(8192);
	localparam logic signed [AW:0] HALF_A = (AW+1)'(8192);

	logic signed [PW-1:0]     pr_s2 [3][3];
	logic signed [AXIS_W-1:0] a_s2 [3], a_s3 [3];
	logic signed [CW-1:0]     p_s2 [3], p_s3 [3], p_s4 [3];
	logic signed [DW-1:0]     dot_s3;
	logic signed [DW-1:0]     cr_s3 [3], cr_s4 [3];
	logic signed [CW+7:0]     ad_s4 [3];

	logic signed [SW-1:0] dsum, csum [3];
	logic signed [SW:0]   dr, cr_r [3];
	logic signed [AW-1:0] adp [3];
	logic signed [AW:0]   ad_r [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s2[i][j] <= PW'(a_in[i]) * PW'(p_in[j]);
				end
				a_s2[i] <= a_in[i];
				p_s2[i] <= p_in[i];
			end
		end
	end

	always_comb begin
		dsum = SW'(pr_s2[0][0]) + SW'(pr_s2[1][1]) + SW'(pr_s2[2][2]);
		csum[0] = SW'(pr_s2[1][2]) - SW'(pr_s2[2][1]);
		csum[1] = SW'(pr_s2[2][0]) - SW'(pr_s2[0][2]);
		csum[2] = SW'(pr_s2[0][1]) - SW'(pr_s2[1][0]);
		dr = (SW+1)'(dsum) + HALF_S;
		for (int k = 0; k < 3; k++) begin
			cr_r[k] = (SW+1)'(csum[k]) + HALF_S;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3 <= dr[SW:14];
			for (int k = 0; k < 3; k++) begin
				cr_s3[k] <= cr_r[k][SW:14];
				a_s3[k]  <= a_s2[k];
				p_s3[k]  <= p_s2[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			adp[k]  = AW'(a_s3[k]) * AW'(dot_s3);
			ad_r[k] = (AW+1)'(adp[k]) + HALF_A;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ad_s4[k] <= ad_r[k][AW:14];
				cr_s4[k] <= cr_s3[k];
				p_s4[k]  <= p_s3[k];
			end
		end
	end

	assign p_out  = p_s4;
	assign cr_out = cr_s4;
	assign ad_out = ad_s4;

endmodule

[hw/rtl/rpa_mix.sv]
module rpa_mix import rpa_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	input  logic                   neg_in,
	input  logic signed [CW-1:0]   p_in [3],
	input  logic signed [CW+4:0]   cr_in [3],
	input  logic signed [CW+7:0]   ad_in [3],
	output logic signed [CW-1:0]   res [3]
);

	localparam int SW = CW + 30;
	localparam logic signed [XY_W:0] HALF_T = (XY_W+1)'(8192);
	localparam logic signed [SW-1:0] HALF_O = SW'(32768);
	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	logic signed [XY_W-1:0] xn, yn;
	logic signed [XY_W:0]   cr, sr;
	logic signed [TRIG_W-1:0] c_s18, s_s18;
	logic signed [OMC_W-1:0]  omc_s18;
	logic signed [CW-1:0]   p_s18 [3];
	logic signed [CW+4:0]   cr_s18 [3];
	logic signed [CW+7:0]   ad_s18 [3];
	logic signed [CW+TRIG_W-1:0]   t0_s19 [3];
	logic signed [CW+5+TRIG_W-1:0] t1_s19 [3];
	logic signed [CW+8+OMC_W-1:0]  t2_s19 [3];
	logic signed [CW-1:0]   out_s20 [3];
	logic signed [SW-1:0]   sum [3];
	logic [SW-1:CW+15]      hi [3];

	always_comb begin
		xn = neg_in ? -x_in : x_in;
		yn = neg_in ? -y_in : y_in;
		cr = (XY_W+1)'(xn) + HALF_T;
		sr = (XY_W+1)'(yn) + HALF_T;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s18   <= cr[XY_W:14];
			s_s18   <= sr[XY_W:14];
			omc_s18 <= OMC_W'(65536) - OMC_W'($signed(cr[XY_W:14]));
			p_s18   <= p_in;
			cr_s18  <= cr_in;
			ad_s18  <= ad_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t0_s19[k] <= (CW+TRIG_W)'(p_s18[k]) * (CW+TRIG_W)'(c_s18);
				t1_s19[k] <= (CW+5+TRIG_W)'(cr_s18[k]) * (CW+5+TRIG_W)'(s_s18);
				t2_s19[k] <= (CW+8+OMC_W)'(ad_s18[k]) * (CW+8+OMC_W)'(omc_s18);
			end
		end
	end

	// round by 16, then saturate when the upper bits are not a sign extension
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = SW'(t0_s19[k]) + SW'(t1_s19[k]) + SW'(t2_s19[k]) + HALF_O;
			hi[k]  = sum[k][SW-1:CW+15];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if ((&hi[k]) || !(|hi[k]))
					out_s20[k] <= sum[k][CW+15:16];
				else
					out_s20[k] <= sum[k][SW-1] ? MINV : MAXV;
			end
		end
	end

	assign res = out_s20;

endmodule

[hw/rtl/rotate_point_about_axis_unit.sv]
// Rotates a point about a unit axis by an angle in 1/64 degree (Rodrigues form,
// right-handed), sine and cosine from a 16-step CORDIC, outputs rounded and saturated.
// Fully pipelined: one transaction per cycle while the output is not stalled, 20
// register stages. The 16 CORDIC iterations, one per stage, set that depth.
// A stall at the output holds the whole pipe; nothing is dropped.
module rotate_point_about_axis_unit import rpa_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rpa_req_if.sink   req,
	rpa_rsp_if.source rsp
);

	localparam int LAT = CORDIC_N + 4;
	localparam int DLY = CORDIC_N - 3;  // geom path finishes at s4, cordic at s17

	logic           en;
	logic [LAT-1:0] vld_q;

	logic signed [AXIS_W-1:0]      a_s1 [3];
	logic signed [COORD_WIDTH-1:0] p_s1 [3];
	logic signed [Z_W-1:0]         z_s1;
	logic                          neg_s1;

	logic signed [ANGLE_W:0] r0, r1, r2;
	logic                    fold;

	logic signed [XY_W-1:0] cx, cy;
	logic                   cneg;
	logic signed [COORD_WIDTH-1:0]   gp [3];
	logic signed [COORD_WIDTH+4:0]   gcr [3];
	logic signed [COORD_WIDTH+7:0]   gad [3];
	logic signed [COORD_WIDTH-1:0]   pd [DLY][3];
	logic signed [COORD_WIDTH+4:0]   crd [DLY][3];
	logic signed [COORD_WIDTH+7:0]   add [DLY][3];
	logic signed [COORD_WIDTH-1:0]   res [3];

	assign en        = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	// reduce to [-half, half) then fold into [-quarter, quarter]
	always_comb begin
		r0 = (ANGLE_W+1)'(req.angle);
		if (r0 >= (ANGLE_W+1)'(HALF_TURN))
			r1 = r0 - (ANGLE_W+1)'(FULL_TURN);
		else if (r0 < -(ANGLE_W+1)'(HALF_TURN))
			r1 = r0 + (ANGLE_W+1)'(FULL_TURN);
		else
			r1 = r0;
		fold = 1'b1;
		if (r1 > (ANGLE_W+1)'(QUARTER_TURN))
			r2 = r1 - (ANGLE_W+1)'(HALF_TURN);
		else if (r1 < -(ANGLE_W+1)'(QUARTER_TURN))
			r2 = r1 + (ANGLE_W+1)'(HALF_TURN);
		else begin
			r2   = r1;
			fold = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= req.axis_x;
			a_s1[1] <= req.axis_y;
			a_s1[2] <= req.axis_z;
			p_s1[0] <= req.point_x;
			p_s1[1] <= req.point_y;
			p_s1[2] <= req.point_z;
			z_s1    <= {Z_W'(r2)} <<< 8;
			neg_s1  <= fold;
		end
	end

	rpa_cordic u_cordic (
		.clk     (clk),
		.en      (en),
		.z_in    (z_s1),
		.neg_in  (neg_s1),
		.x_out   (cx),
		.y_out   (cy),
		.neg_out (cneg)
	);

	rpa_geom #(.CW(COORD_WIDTH)) u_geom (
		.clk    (clk),
		.en     (en),
		.a_in   (a_s1),
		.p_in   (p_s1),
		.p_out  (gp),
		.cr_out (gcr),
		.ad_out (gad)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pd[0]  <= gp;
			crd[0] <= gcr;
			add[0] <= gad;
			for (int d = 1; d < DLY; d++) begin
				pd[d]  <= pd[d-1];
				crd[d] <= crd[d-1];
				add[d] <= add[d-1];
			end
		end
	end

	rpa_mix #(.CW(COORD_WIDTH)) u_mix (
		.clk    (clk),
		.en     (en),
		.x_in   (cx),
		.y_in   (cy),
		.neg_in (cneg),
		.p_in   (pd[DLY-1]),
		.cr_in  (crd[DLY-1]),
		.ad_in  (add[DLY-1]),
		.res    (res)
	);

	assign rsp.valid = vld_q[LAT-1];
	assign rsp.out_x = res[0];
	assign rsp.out_y = res[1];
	assign rsp.out_z = res[2];

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input taken while output stalled");

	a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_q[0])
		else $error("accepted transaction not tracked");

	a_stall_holds_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule
